[sv/sfr_pkg.sv]
// sfr_pkg: shared constants, register indexes and cell control types
// for the stream find-and-replace block
// no dependencies
package sfr_pkg;

   // fixed field and register widths
   localparam int unsigned ByteWidth     = 8;
   localparam int unsigned RegWidth      = 64;
   localparam int unsigned LenWidth      = 4;
   localparam int unsigned CsrIndexWidth = 2;

   // default sizes handed to the top level parameters
   localparam int unsigned DefMaxPattern     = 8;
   localparam int unsigned DefMaxReplacement = 8;

   // character and item kind codes
   localparam logic [ByteWidth-1:0] NewlineChar = 8'h0A;
   localparam logic                 KindText    = 1'b0;
   localparam logic                 KindFlush   = 1'b1;

   // configuration register indexes
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_PATTERN_BYTES      = 2'd0,
      CSR_PATTERN_LENGTH     = 2'd1,
      CSR_REPLACEMENT_BYTES  = 2'd2,
      CSR_REPLACEMENT_LENGTH = 2'd3
   } csr_index_type;

   // per-cell control from the top level
   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

endpackage

[sv/sfr_stream_if.sv]
// sfr_stream_if: valid/ready channel interfaces for the request and
// response streams of the find-and-replace block
// depends on sfr_pkg
interface sfr_req_if;
   import sfr_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [ByteWidth-1:0] text_byte;

   modport source  (output valid, kind, text_byte, input ready);
   modport sink    (input valid, kind, text_byte, output ready);
   modport monitor (input valid, ready, kind, text_byte);
endinterface

interface sfr_rsp_if;
   import sfr_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] out_byte;
   logic                 last;

   modport source  (output valid, out_byte, last, input ready);
   modport sink    (input valid, out_byte, last, output ready);
   modport monitor (input valid, ready, out_byte, last);
endinterface

[sv/stream_find_replace.sv]
// stream_find_replace: top level; window row of match cells, decision
// logic, output burst row and configuration registers
// depends on sfr_pkg, sfr_stream_if, sfr_win_cell, sfr_out_cell
//
// Streaming find-and-replace: text bytes enter on req_chan, the rewritten
// stream leaves on rsp_chan one byte per transaction, with last set on the
// final byte caused by a request. Each window cell compares its byte with
// one pattern byte, and results start the cycle after a request is taken.
// A request whose results are one byte or none is followed by the next one
// in the next cycle while the receiver is ready, a sustained rate of one
// byte per cycle. A request that yields n results (a replacement of n
// bytes, or a newline or flush draining the window) holds the output burst
// row until its last byte is delivered, and the next request is taken in
// the cycle that byte is delivered. The user must write configuration
// through csr_* while the stream is idle; the block does not enforce this.
module stream_find_replace #(
   parameter int unsigned MAX_PATTERN     = sfr_pkg::DefMaxPattern,
   parameter int unsigned MAX_REPLACEMENT = sfr_pkg::DefMaxReplacement
) (
   input  logic                              clock,
   input  logic                              reset,
   sfr_req_if.sink                           req_chan,
   sfr_rsp_if.source                         rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [sfr_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [sfr_pkg::RegWidth-1:0]      csr_wdata
);
   import sfr_pkg::*;

   localparam int unsigned WinDepth = MAX_PATTERN;
   localparam int unsigned JobDepth =
      (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
   localparam int unsigned FillWidth = $clog2(WinDepth + 1);
   localparam int unsigned CntWidth  = $clog2(JobDepth + 1);

   // configuration registers
   logic [RegWidth-1:0] pattern_bytes_ff,      pattern_bytes_in;
   logic [LenWidth-1:0] pattern_length_ff,     pattern_length_in;
   logic [RegWidth-1:0] replacement_bytes_ff,  replacement_bytes_in;
   logic [LenWidth-1:0] replacement_length_ff, replacement_length_in;

   // window state
   logic [FillWidth-1:0] fill_ff, fill_in;
   logic                 line_open_ff, line_open_in;
   logic [CntWidth-1:0]  job_cnt_ff, job_cnt_in;

   // datapath signals
   cell_ctrl_type        win_ctrl   [WinDepth];
   logic [ByteWidth-1:0] win_cur    [WinDepth];
   logic [ByteWidth-1:0] win_shift  [WinDepth];
   logic                 win_hit    [WinDepth];
   logic [ByteWidth-1:0] win_pad    [JobDepth];
   cell_ctrl_type        out_ctrl;
   logic [ByteWidth-1:0] out_held   [JobDepth];
   logic [ByteWidth-1:0] out_shift  [JobDepth];
   logic [ByteWidth-1:0] job_byte   [JobDepth];
   logic [CntWidth-1:0]  job_cnt;

   logic                 accept;
   logic                 take;
   logic                 is_flush;
   logic                 is_newline;
   logic                 append;
   logic                 decide;
   logic                 hit_all;
   logic [FillWidth-1:0] fill_post;
   logic [FillWidth-1:0] plen;
   logic [CntWidth-1:0]  rlen;
   logic [FillWidth-1:0] shamt;

   // configuration writes
   always_comb begin
      pattern_bytes_in      = pattern_bytes_ff;
      pattern_length_in     = pattern_length_ff;
      replacement_bytes_in  = replacement_bytes_ff;
      replacement_length_in = replacement_length_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATTERN_BYTES:      pattern_bytes_in      = csr_wdata;
            CSR_PATTERN_LENGTH:     pattern_length_in     = csr_wdata[LenWidth-1:0];
            CSR_REPLACEMENT_BYTES:  replacement_bytes_in  = csr_wdata;
            CSR_REPLACEMENT_LENGTH: replacement_length_in = csr_wdata[LenWidth-1:0];
            default: begin
               pattern_bytes_in = pattern_bytes_ff;
            end
         endcase
      end
   end

   // effective lengths, zero acts as one, large values saturate
   always_comb begin
      if (pattern_length_ff == '0) begin
         plen = FillWidth'(1);
      end else if (pattern_length_ff > LenWidth'(WinDepth)) begin
         plen = FillWidth'(WinDepth);
      end else begin
         plen = FillWidth'(pattern_length_ff);
      end
      if (replacement_length_ff == '0) begin
         rlen = CntWidth'(1);
      end else if (replacement_length_ff > LenWidth'(MAX_REPLACEMENT)) begin
         rlen = CntWidth'(MAX_REPLACEMENT);
      end else begin
         rlen = CntWidth'(replacement_length_ff);
      end
   end

   // handshake and request decode
   assign take       = rsp_chan.valid && rsp_chan.ready;
   assign accept     = req_chan.valid && req_chan.ready;
   assign is_flush   = (req_chan.kind == KindFlush);
   assign is_newline = !is_flush && (req_chan.text_byte == NewlineChar);
   assign append     = accept && !is_flush && !is_newline;
   assign fill_post  = fill_ff + FillWidth'(1);
   assign decide     = append && (fill_post >= plen);

   // pattern match over the leading cells
   always_comb begin
      hit_all = 1'b1;
      for (int i = 0; i < WinDepth; i++) begin
         if ((FillWidth'(i) < plen) && !win_hit[i]) begin
            hit_all = 1'b0;
         end
      end
      shamt = hit_all ? plen : FillWidth'(1);
   end

   // shift source for each window cell
   always_comb begin
      for (int i = 0; i < WinDepth; i++) begin
         win_shift[i] = '0;
         for (int k = 0; k < WinDepth; k++) begin
            if ((FillWidth + 1)'(k) ==
                ({1'b0, FillWidth'(i)} + {1'b0, shamt})) begin
               win_shift[i] = win_cur[k];
            end
         end
         win_ctrl[i].load  = append && (fill_ff == FillWidth'(i));
         win_ctrl[i].shift = decide;
      end
   end

   // window row
   for (genvar i = 0; i < WinDepth; i++) begin : g_win
      sfr_win_cell u_cell (
         .clock      (clock),
         .ctrl       (win_ctrl[i]),
         .new_byte   (req_chan.text_byte),
         .shift_byte (win_shift[i]),
         .pat_byte   (pattern_bytes_ff[ByteWidth*i +: ByteWidth]),
         .cur_byte   (win_cur[i]),
         .hit        (win_hit[i])
      );
   end

   // window bytes padded to burst depth
   for (genvar k = 0; k < JobDepth; k++) begin : g_pad
      if (k < WinDepth) begin : g_in
         assign win_pad[k] = win_cur[k];
      end else begin : g_out
         assign win_pad[k] = '0;
      end
   end

   // burst built from one request
   always_comb begin
      job_cnt = '0;
      for (int k = 0; k < JobDepth; k++) begin
         job_byte[k] = '0;
      end
      if (!is_flush && !is_newline) begin
         if (decide && hit_all) begin
            for (int k = 0; k < JobDepth; k++) begin
               job_byte[k] = replacement_bytes_ff[ByteWidth*k +: ByteWidth];
            end
            job_cnt = rlen;
         end else if (decide) begin
            job_byte[0] = win_cur[0];
            job_cnt     = CntWidth'(1);
         end
      end else begin
         // drain held bytes, then the line end for a newline or an open line
         for (int k = 0; k < JobDepth; k++) begin
            if (CntWidth'(k) < CntWidth'(fill_ff)) begin
               job_byte[k] = win_pad[k];
            end else if (CntWidth'(k) == CntWidth'(fill_ff)) begin
               job_byte[k] = NewlineChar;
            end
         end
         if (is_newline) begin
            job_cnt = CntWidth'(fill_ff) + CntWidth'(1);
         end else begin
            job_cnt = CntWidth'(fill_ff) + CntWidth'(line_open_ff);
         end
      end
   end

   // window fill and line state
   always_comb begin
      fill_in      = fill_ff;
      line_open_in = line_open_ff;
      if (accept) begin
         if (is_flush || is_newline) begin
            fill_in      = '0;
            line_open_in = 1'b0;
         end else begin
            fill_in      = decide ? (fill_post - shamt) : fill_post;
            line_open_in = 1'b1;
         end
      end
   end

   // output burst row
   assign out_ctrl.load  = accept;
   assign out_ctrl.shift = take;

   for (genvar k = 0; k < JobDepth; k++) begin : g_out
      if (k + 1 < JobDepth) begin : g_mid
         assign out_shift[k] = out_held[k+1];
      end else begin : g_end
         assign out_shift[k] = '0;
      end
      sfr_out_cell u_cell (
         .clock      (clock),
         .ctrl       (out_ctrl),
         .load_byte  (job_byte[k]),
         .shift_byte (out_shift[k]),
         .held_byte  (out_held[k])
      );
   end

   // burst count
   always_comb begin
      if (accept) begin
         job_cnt_in = job_cnt;
      end else if (take) begin
         job_cnt_in = job_cnt_ff - CntWidth'(1);
      end else begin
         job_cnt_in = job_cnt_ff;
      end
   end

   // ports
   assign req_chan.ready  = (job_cnt_ff == '0) ||
                            (rsp_chan.ready && (job_cnt_ff == CntWidth'(1)));
   assign rsp_chan.valid    = (job_cnt_ff != '0);
   assign rsp_chan.out_byte = out_held[0];
   assign rsp_chan.last     = (job_cnt_ff == CntWidth'(1));

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff      <= '0;
         pattern_length_ff     <= LenWidth'(1);
         replacement_bytes_ff  <= '0;
         replacement_length_ff <= LenWidth'(1);
         fill_ff               <= '0;
         line_open_ff          <= 1'b0;
         job_cnt_ff            <= '0;
      end else begin
         pattern_bytes_ff      <= pattern_bytes_in;
         pattern_length_ff     <= pattern_length_in;
         replacement_bytes_ff  <= replacement_bytes_in;
         replacement_length_ff <= replacement_length_in;
         fill_ff               <= fill_in;
         line_open_ff          <= line_open_in;
         job_cnt_ff            <= job_cnt_in;
      end
   end

endmodule

[sv/sfr_win_cell.sv]
// sfr_win_cell: one byte of the match window; takes a new byte, compares
// it with its pattern byte and hands its byte down the row on a decision
// depends on sfr_pkg
module sfr_win_cell (
   input  logic                          clock,
   input  sfr_pkg::cell_ctrl_type        ctrl,
   input  logic [sfr_pkg::ByteWidth-1:0] new_byte,
   input  logic [sfr_pkg::ByteWidth-1:0] shift_byte,
   input  logic [sfr_pkg::ByteWidth-1:0] pat_byte,
   output logic [sfr_pkg::ByteWidth-1:0] cur_byte,
   output logic                          hit
);
   import sfr_pkg::*;

   logic [ByteWidth-1:0] byte_ff;
   logic [ByteWidth-1:0] byte_in;

   // byte as seen after the incoming character lands
   assign cur_byte = ctrl.load ? new_byte : byte_ff;
   assign hit      = (cur_byte == pat_byte);

   // shift from the row or keep
   assign byte_in = ctrl.shift ? shift_byte : cur_byte;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

[sv/sfr_out_cell.sv]
// sfr_out_cell: one byte of the output burst row; loads a burst byte and
// moves toward the response port one place per delivered byte
// depends on sfr_pkg
module sfr_out_cell (
   input  logic                          clock,
   input  sfr_pkg::cell_ctrl_type        ctrl,
   input  logic [sfr_pkg::ByteWidth-1:0] load_byte,
   input  logic [sfr_pkg::ByteWidth-1:0] shift_byte,
   output logic [sfr_pkg::ByteWidth-1:0] held_byte
);
   import sfr_pkg::*;

   logic [ByteWidth-1:0] byte_ff;
   logic [ByteWidth-1:0] byte_in;

   // new burst wins over the shift
   always_comb begin
      if (ctrl.load) begin
         byte_in = load_byte;
      end else if (ctrl.shift) begin
         byte_in = shift_byte;
      end else begin
         byte_in = byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign held_byte = byte_ff;

endmodule

[sv/sfr_checker.sv]
// sfr_checker: port-level assertions for stream_find_replace and the bind
// that attaches them
// depends on stream_find_replace as the bind target
module sfr_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  logic rsp_last
);

   // response held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transaction");

   // no new request while a burst has more than its final byte left
   a_burst_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request taken during unfinished burst");

   // a stalled response blocks the request side
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response stalled");

   // a burst continues after a non-final byte
   a_burst_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("burst ended without last");

   // nothing pending out of reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_last  (rsp_chan.last)
);

[sim/tb.sv]
// tb: self-checking testbench for stream_find_replace, with a byte-level
// rewrite predictor, randomized sender bursts and receiver stalls
// depends on sfr_pkg, sfr_stream_if and the stream_find_replace rtl
module tb;
   import sfr_pkg::*;

   localparam int unsigned QuietLimit   = 2000;
   localparam int unsigned SettleCycles = 4;
   localparam int unsigned WinDepth     = 8;
   localparam int unsigned PhaseItems   = 40;
   localparam int unsigned PhaseCount   = 8;

   typedef struct packed {
      logic [ByteWidth-1:0] out_byte;
      logic                 last;
   } out_beat_type;

   logic                     clock;
   logic                     reset;
   logic                     csr_wr_en;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [RegWidth-1:0]      csr_wdata;

   sfr_req_if req ();
   sfr_rsp_if rsp ();

   stream_find_replace dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req),
      .rsp_chan  (rsp),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state and its copy of the registers
   logic [ByteWidth-1:0] win_q [WinDepth];
   int unsigned          win_fill;
   bit                   line_open_q;
   logic [RegWidth-1:0]  pat_word;
   logic [LenWidth-1:0]  pat_len_q;
   logic [RegWidth-1:0]  rep_word;
   logic [LenWidth-1:0]  rep_len_q;

   out_beat_type rewritten_q [$];
   out_beat_type head;
   int unsigned  mismatches;
   int unsigned  quiet_cycles;
   int unsigned  burst_left;

   // receiver stall pattern state
   int unsigned rx_tick;
   int unsigned rx_mode;
   int unsigned rx_run_left;
   bit          rx_run_level;

   // clock
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // mismatch reporting
   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
   endtask

   function automatic int unsigned clamp_length(input logic [LenWidth-1:0] v,
                                               input int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   // remove the n oldest window bytes
   function automatic void shift_window(input int unsigned n);
      int unsigned i;
      if (n >= win_fill) begin
         win_fill = 0;
         return;
      end
      for (i = 0; i + n < win_fill; i++) win_q[i] = win_q[i + n];
      win_fill -= n;
   endfunction

   function automatic void push_beat(input logic [ByteWidth-1:0] b, inout int unsigned n);
      rewritten_q.push_back('{out_byte: b, last: 1'b0});
      n++;
   endfunction

   // predict the rewritten bytes caused by one accepted transaction
   function automatic void rewrite_item(input logic kind, input logic [ByteWidth-1:0] ch);
      int unsigned plen;
      int unsigned rlen;
      int unsigned i;
      int unsigned n;
      bit          hit;
      plen = clamp_length(pat_len_q, DefMaxPattern);
      rlen = clamp_length(rep_len_q, DefMaxReplacement);
      n = 0;
      if (kind == KindFlush || ch == NewlineChar) begin
         for (i = 0; i < win_fill; i++) push_beat(win_q[i], n);
         win_fill = 0;
         if (kind != KindFlush || line_open_q) push_beat(NewlineChar, n);
         line_open_q = 1'b0;
      end else begin
         line_open_q = 1'b1;
         if (win_fill < WinDepth) begin
            win_q[win_fill] = ch;
            win_fill++;
         end
         if (win_fill >= plen) begin
            hit = 1'b1;
            for (i = 0; i < plen; i++)
               if (win_q[i] != pat_word[8*i +: 8]) hit = 1'b0;
            if (hit) begin
               for (i = 0; i < rlen; i++) push_beat(rep_word[8*i +: 8], n);
               shift_window(plen);
            end else begin
               push_beat(win_q[0], n);
               shift_window(1);
            end
         end
      end
      if (n > 0) rewritten_q[rewritten_q.size() - 1].last = 1'b1;
   endfunction

   // register write, mirrored into the predictor
   task automatic write_csr(input csr_index_type idx, input logic [RegWidth-1:0] data);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         CSR_PATTERN_BYTES:      pat_word  = data;
         CSR_PATTERN_LENGTH:     pat_len_q = data[LenWidth-1:0];
         CSR_REPLACEMENT_BYTES:  rep_word  = data;
         CSR_REPLACEMENT_LENGTH: rep_len_q = data[LenWidth-1:0];
         default: ;
      endcase
   endtask

   // all four registers; length writes carry random upper bits
   task automatic configure(input logic [RegWidth-1:0] pword, input logic [LenWidth-1:0] plen,
                            input logic [RegWidth-1:0] rword, input logic [LenWidth-1:0] rlen);
      logic [RegWidth-1:0] data;
      write_csr(CSR_PATTERN_BYTES, pword);
      data = {$urandom, $urandom};
      data[LenWidth-1:0] = plen;
      write_csr(CSR_PATTERN_LENGTH, data);
      write_csr(CSR_REPLACEMENT_BYTES, rword);
      data = {$urandom, $urandom};
      data[LenWidth-1:0] = rlen;
      write_csr(CSR_REPLACEMENT_LENGTH, data);
   endtask

   // send one transaction, then maybe open a gap in the burst
   task automatic send_item(input logic kind, input logic [ByteWidth-1:0] ch);
      int unsigned gap;
      @(negedge clock);
      req.valid     = 1'b1;
      req.kind      = kind;
      req.text_byte = ch;
      do @(posedge clock); while (!req.ready);
      rewrite_item(kind, ch);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req.valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   // stop sending and let every pending result drain
   task automatic wait_idle();
      @(negedge clock);
      req.valid = 1'b0;
      while (rewritten_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // reset defaults, flush of an empty stream, flush of an open line
   task automatic test_defaults_and_flush();
      send_item(KindFlush, 8'hFF);
      send_item(KindText, 8'h00);
      send_item(KindText, 8'hFF);
      send_item(KindFlush, 8'h00);
      wait_idle();
   endtask

   // replacement longer than the pattern, leftmost match wins
   task automatic test_grow_replace();
      configure(64'h6261, 4'd2, 64'h5A5958, 4'd3);
      send_item(KindText, "a");
      send_item(KindText, "a");
      send_item(KindText, "b");
      send_item(KindText, "a");
      send_item(KindFlush, 8'h00);
      wait_idle();
   endtask

   // full-width pattern and replacement, lengths 0 and 15 clamp
   task automatic test_extreme_lengths();
      int unsigned i;
      configure({RegWidth{1'b1}}, 4'd15, {$urandom, $urandom}, 4'd0);
      for (i = 0; i < 8; i++) send_item(KindText, 8'hFF);
      wait_idle();
      configure('0, 4'd0, {$urandom, $urandom}, 4'd15);
      send_item(KindText, 8'h00);
      send_item(KindText, NewlineChar);
      wait_idle();
   endtask

   // a pattern holding a newline never matches
   task automatic test_newline_in_pattern();
      configure({48'h0, NewlineChar, 8'h61}, 4'd2, 64'h2A, 4'd1);
      send_item(KindText, "a");
      send_item(KindText, NewlineChar);
      wait_idle();
   endtask

   // pattern shortened while the window holds more bytes than it needs
   task automatic test_pattern_shortened();
      configure(64'h65_6463_6261, 4'd5, 64'h2B2B, 4'd2);
      send_item(KindText, "a");
      send_item(KindText, "b");
      send_item(KindText, "c");
      send_item(KindText, "d");
      wait_idle();
      write_csr(CSR_PATTERN_LENGTH, 64'd2);
      send_item(KindText, "x");
      send_item(KindText, NewlineChar);
      wait_idle();
   endtask

   // random streams built mostly from pattern bytes and whole pattern copies
   task automatic test_random_streams();
      logic [ByteWidth-1:0] alphabet [4];
      logic [RegWidth-1:0]  pword;
      logic [LenWidth-1:0]  plen_w;
      logic [LenWidth-1:0]  rlen_w;
      int unsigned          phase;
      int unsigned          sent;
      int unsigned          plen_eff;
      int unsigned          r;
      int unsigned          i;
      for (phase = 0; phase < PhaseCount; phase++) begin
         for (i = 0; i < 4; i++) alphabet[i] = ByteWidth'($urandom_range(0, 255));
         for (i = 0; i < 8; i++) begin
            r = $urandom_range(0, 15);
            if (r == 0) pword[8*i +: 8] = NewlineChar;
            else if (r == 1) pword[8*i +: 8] = ByteWidth'($urandom_range(0, 255));
            else pword[8*i +: 8] = alphabet[$urandom_range(0, 3)];
         end
         plen_w = LenWidth'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 15)
                                                        : $urandom_range(1, 8));
         rlen_w = LenWidth'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 15)
                                                        : $urandom_range(1, 8));
         case (phase)
            0: begin pword = '0; plen_w = 4'd1; rlen_w = 4'd8; end
            1: begin pword = {RegWidth{1'b1}}; plen_w = 4'd8; rlen_w = 4'd1; end
            2: begin plen_w = 4'd0; rlen_w = 4'd15; end
            3: begin plen_w = 4'd15; rlen_w = 4'd0; end
            default: ;
         endcase
         configure(pword, plen_w, {$urandom, $urandom}, rlen_w);
         plen_eff = clamp_length(plen_w, DefMaxPattern);
         sent = 0;
         while (sent < PhaseItems) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
               for (i = 0; i < plen_eff; i++) send_item(KindText, pword[8*i +: 8]);
               sent += plen_eff;
            end else begin
               if (r < 75) send_item(KindText, pword[8*$urandom_range(0, plen_eff - 1) +: 8]);
               else if (r < 88) send_item(KindText, ByteWidth'($urandom_range(0, 255)));
               else if (r < 96) send_item(KindText, NewlineChar);
               else send_item(KindFlush, ByteWidth'($urandom_range(0, 255)));
               sent++;
            end
         end
         // odd phases close the stream with a flush, even ones add no flush
         if (phase % 2 == 1) send_item(KindFlush, ByteWidth'($urandom_range(0, 255)));
         wait_idle();
      end
   endtask

   // receiver stall pattern, in one of four randomly chosen modes
   always @(negedge clock) begin
      rx_tick++;
      if (rx_tick % 96 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
         0: rsp.ready = 1'b1;
         1: rsp.ready = ($urandom_range(0, 3) != 0);
         2: rsp.ready = (rx_tick % 5) > 1;
         default: begin
            if (rx_run_left == 0) begin
               rx_run_left  = $urandom_range(1, 8);
               rx_run_level = ~rx_run_level;
            end
            rsp.ready = rx_run_level;
            rx_run_left--;
         end
      endcase
   end

   // check each response transaction against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (rewritten_q.size() == 0) begin
            report_mismatch($sformatf("response %02h with nothing pending", rsp.out_byte));
         end else begin
            head = rewritten_q.pop_front();
            if (rsp.out_byte !== head.out_byte)
               report_mismatch($sformatf("out_byte %02h, predicted %02h",
                                         rsp.out_byte, head.out_byte));
            if (rsp.last !== head.last)
               report_mismatch($sformatf("last %b, predicted %b", rsp.last, head.last));
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QuietLimit) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // test sequence
   initial begin
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_index     = CSR_PATTERN_BYTES;
      csr_wdata     = '0;
      req.valid     = 1'b0;
      req.kind      = KindText;
      req.text_byte = '0;
      rsp.ready     = 1'b0;
      rx_tick       = 0;
      rx_mode       = 0;
      rx_run_left   = 0;
      rx_run_level  = 1'b0;
      mismatches    = 0;
      quiet_cycles  = 0;
      burst_left    = $urandom_range(1, 24);
      for (int i = 0; i < WinDepth; i++) win_q[i] = '0;
      win_fill    = 0;
      line_open_q = 1'b0;
      pat_word    = '0;
      pat_len_q   = 4'd1;
      rep_word    = '0;
      rep_len_q   = 4'd1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_defaults_and_flush();
      test_grow_replace();
      test_extreme_lengths();
      test_newline_in_pattern();
      test_pattern_shortened();
      test_random_streams();

      wait_idle();
      repeat (SettleCycles) @(posedge clock);
      if (mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

[files.f]
sv/sfr_pkg.sv
sv/sfr_stream_if.sv
sv/sfr_win_cell.sv
sv/sfr_out_cell.sv
sv/stream_find_replace.sv
sv/sfr_checker.sv
sim/tb.sv
